[hw/rtl/crc8pfr_pkg.sv]
// Shared types, codes and the CRC-8 byte update for the packet frame receiver.
`default_nettype none

package crc8pfr_pkg;

    // Receiver phase
    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    // Per-byte verdict codes
    typedef enum logic [3:0] {
        V_IGNORED      = 4'd0,
        V_HEADER       = 4'd1,
        V_BODY         = 4'd2,
        V_HDR_CRC_BAD  = 4'd3,
        V_WRONG_UNIT   = 4'd4,
        V_LENGTH_BAD   = 4'd5,
        V_NO_END_MARK  = 4'd6,
        V_FRAME_CRC_BAD = 4'd7,
        V_ADDR_MISMATCH = 4'd8,
        V_ACCEPTED     = 4'd9
    } verdict_t;

    // Register word indexes (byte address / 4)
    localparam logic [1:0] REG_UNIT_ID     = 2'd0;
    localparam logic [1:0] REG_OWN_ADDRESS = 2'd1;
    localparam logic [1:0] REG_END_MARKER  = 2'd2;
    localparam logic [1:0] REG_MIN_LENGTH  = 2'd3;

    localparam logic [7:0] ID_BASE        = 8'h10;
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
    localparam int unsigned HEADER_CRC_POS = 6;
    localparam logic [9:0] MIN_LEN_FLOOR  = 10'd8;

    localparam logic [7:0] END_MARKER_RST = 8'h04;

    typedef struct packed {
        logic [7:0] unit_id;
        logic [7:0] own_address;
        logic [7:0] end_marker;
        logic [9:0] min_length;
    } cfg_t;

    // Result word, first field in the highest bits
    typedef struct packed {
        logic [9:0] packet_length;
        logic [7:0] sender_address;
        verdict_t   verdict;
        logic [9:0] byte_index;
    } res_t;

    // One-wire CRC-8, reflected polynomial 0x8C, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/crc8pfr_frame_fsm.sv]
// Frame state machine: running CRC, header fields and per-byte verdict.
`default_nettype none

module crc8pfr_frame_fsm #(
    parameter int unsigned BUFFER_SIZE = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              frame_start,
    input  wire crc8pfr_pkg::cfg_t cfg,
    output crc8pfr_pkg::res_t      res
);
    import crc8pfr_pkg::*;

    localparam int unsigned PW = ($clog2(BUFFER_SIZE) > 10) ? $clog2(BUFFER_SIZE) : 10;
    localparam int unsigned LW = 17;
    localparam logic [LW-1:0] LEN_LIMIT = LW'(BUFFER_SIZE - 6);

    phase_t         phase_reg, phase_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [7:0]     crc_reg, crc_next;
    logic [15:0]    len_reg, len_next;
    logic [7:0]     dest_reg, dest_next;
    logic [7:0]     src_reg, src_next;
    logic [7:0]     id_reg, id_next;
    logic           fcok_reg, fcok_next;

    // State as seen by this byte (a start byte sees a cleared receiver)
    logic           active;
    phase_t         eff_phase;
    logic [PW-1:0]  eff_pos;
    logic [7:0]     eff_crc;
    logic [15:0]    eff_len;
    logic [7:0]     eff_dest, eff_src, eff_id;
    logic           eff_fcok;
    logic [LW-1:0]  pos_ext, len_ext;
    logic           past_header, at_end, hdr_ok;
    logic [9:0]     minimum;
    verdict_t       verdict;

    assign active    = frame_start || (phase_reg == PH_HEADER) || (phase_reg == PH_BODY);
    assign eff_phase = frame_start ? PH_HEADER : phase_reg;
    assign eff_pos   = frame_start ? '0 : pos_reg;
    assign eff_crc   = frame_start ? '0 : crc_reg;
    assign eff_len   = frame_start ? '0 : len_reg;
    assign eff_dest  = frame_start ? '0 : dest_reg;
    assign eff_src   = frame_start ? '0 : src_reg;
    assign eff_id    = frame_start ? '0 : id_reg;
    assign eff_fcok  = frame_start ? 1'b0 : fcok_reg;
    assign minimum   = (cfg.min_length < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : cfg.min_length;

    always_comb
    begin
        id_next   = (eff_pos == PW'(0)) ? rx_byte : eff_id;
        dest_next = (eff_pos == PW'(1)) ? rx_byte : eff_dest;
        src_next  = (eff_pos == PW'(3)) ? rx_byte : eff_src;
        len_next  = eff_len;
        if (eff_pos == PW'(4))
        begin
            len_next[7:0] = rx_byte;
        end
        if (eff_pos == PW'(5))
        begin
            len_next[15:8] = rx_byte;
        end
    end

    assign pos_ext     = LW'(eff_pos);
    assign len_ext     = LW'(len_next);
    assign past_header = (eff_pos >= PW'(HEADER_CRC_POS));
    assign at_end      = (pos_ext + LW'(1)) >= len_ext;
    // Frame CRC byte sits two before the length
    assign fcok_next   = (past_header && ((pos_ext + LW'(2)) == len_ext))
                         ? (eff_crc == rx_byte) : eff_fcok;

    // Verdict and header-accept flag
    always_comb
    begin
        verdict = V_IGNORED;
        hdr_ok  = 1'b0;
        if (active)
        begin
            case (eff_phase)
                PH_HEADER:
                begin
                    if (!past_header)
                    begin
                        verdict = V_HEADER;
                    end
                    else if (eff_crc != rx_byte)
                    begin
                        verdict = V_HDR_CRC_BAD;
                    end
                    else if ({1'b0, id_next} != ({1'b0, ID_BASE} + {1'b0, cfg.unit_id}))
                    begin
                        verdict = V_WRONG_UNIT;
                    end
                    else if ((len_next < {6'd0, minimum}) || (len_ext >= LEN_LIMIT))
                    begin
                        verdict = V_LENGTH_BAD;
                    end
                    else
                    begin
                        verdict = V_HEADER;
                        hdr_ok  = 1'b1;
                    end
                end
                default:
                begin
                    if (!at_end)
                    begin
                        verdict = V_BODY;
                    end
                    else if (rx_byte != cfg.end_marker)
                    begin
                        verdict = V_NO_END_MARK;
                    end
                    else if (!fcok_next)
                    begin
                        verdict = V_FRAME_CRC_BAD;
                    end
                    else if ((dest_next != cfg.own_address) && (dest_next != BROADCAST_ADDR))
                    begin
                        verdict = V_ADDR_MISMATCH;
                    end
                    else
                    begin
                        verdict = V_ACCEPTED;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res.byte_index     = active ? eff_pos[9:0] : '0;
        res.verdict        = verdict;
        res.sender_address = (verdict == V_ACCEPTED) ? src_next : '0;
        res.packet_length  = (active && past_header) ? len_next[9:0] : '0;
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (active)
        begin
            case (eff_phase)
                PH_HEADER:
                begin
                    if (!past_header || hdr_ok)
                    begin
                        phase_next = hdr_ok ? PH_BODY : PH_HEADER;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_BODY:
                begin
                    phase_next = at_end ? PH_WAIT : PH_BODY;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    assign crc_next = crc8_byte(eff_crc, rx_byte);
    assign pos_next = eff_pos + PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            pos_reg   <= '0;
            crc_reg   <= '0;
            len_reg   <= '0;
            dest_reg  <= '0;
            src_reg   <= '0;
            id_reg    <= '0;
            fcok_reg  <= 1'b0;
        end
        else if (step && active)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            len_reg   <= len_next;
            dest_reg  <= dest_next;
            src_reg   <= src_next;
            id_reg    <= id_next;
            fcok_reg  <= fcok_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/crc8_packet_frame_receiver_top.sv]
// Packet frame receiver top level: stream ports, register port, pipeline registers.
//
// Usage:
//   Slave stream (s_*): one packet byte per word in s_tdata[7:0]; s_tuser is
//   high on the first byte after sync and restarts the receiver.
//   Master stream (m_*): one result word per input word, carrying the byte
//   index, a verdict code, the sender address (accepted frames only) and the
//   packet length field once the header has been checked.
//   Register port: unit_id at 0x0, own_address at 0x4, end_marker at 0x8,
//   min_length at 0xC; write only while no word is in flight.
// Path: each word is held in the input register, its result in the result register.
// Throughput: one word per cycle while m_tready is high; the CRC update and all
//   checks are one short combinational step between input and result register.
// Reset: rst_n clears both stages, the receiver returns to waiting for sync,
//   registers take their reset values (end_marker 4, min_length 8).
// Stall: while m_tready is low the result register holds; the input register
//   still takes one more word, then s_tready drops until the result drains.
`default_nettype none

module crc8_packet_frame_receiver_top #(
    parameter int unsigned BUFFER_SIZE = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] frame_start
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [9:0] byte_index, [13:10] verdict,
                                        // [21:14] sender_address, [31:22] packet_length
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import crc8pfr_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       out_valid_reg;
    res_t       out_data_reg;
    res_t       res;
    logic       advance;
    logic       cfg_wr;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_id     <= '0;
            cfg_reg.own_address <= '0;
            cfg_reg.end_marker  <= END_MARKER_RST;
            cfg_reg.min_length  <= MIN_LEN_FLOOR;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_UNIT_ID:     cfg_reg.unit_id     <= pwdata[7:0];
                REG_OWN_ADDRESS: cfg_reg.own_address <= pwdata[7:0];
                REG_END_MARKER:  cfg_reg.end_marker  <= pwdata[7:0];
                REG_MIN_LENGTH:  cfg_reg.min_length  <= pwdata[9:0];
                default:         cfg_reg.unit_id     <= cfg_reg.unit_id;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_UNIT_ID:     prdata = {24'd0, cfg_reg.unit_id};
            REG_OWN_ADDRESS: prdata = {24'd0, cfg_reg.own_address};
            REG_END_MARKER:  prdata = {24'd0, cfg_reg.end_marker};
            REG_MIN_LENGTH:  prdata = {22'd0, cfg_reg.min_length};
            default:         prdata = '0;
        endcase
    end

    // Input stage moves on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    crc8pfr_frame_fsm #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .frame_start (in_start_reg),
        .cfg         (cfg_reg),
        .res         (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
